// ===== hw/rtl/ica_pkg.sv =====
// Shared types and codes for the integer calculator ALU.
// Holds the port words, opcode and status codes, and the controller/datapath interface.
// No dependencies.
`timescale 1ns / 1ps

package ica_pkg;

    // Input word: opcode and two signed 32-bit operands.
    typedef struct packed {
        logic [2:0]         opcode;
        logic signed [31:0] operand_a;
        logic signed [31:0] operand_b;
    } in_word_t;

    // Output word: wrapped result and status code.
    typedef struct packed {
        logic signed [31:0] value;
        logic [1:0]         status;
    } out_word_t;

    // Opcodes.
    localparam logic [2:0] OP_ADD  = 3'd0;
    localparam logic [2:0] OP_SUB  = 3'd1;
    localparam logic [2:0] OP_MUL  = 3'd2;
    localparam logic [2:0] OP_DIV  = 3'd3;
    localparam logic [2:0] OP_FACT = 3'd4;
    localparam logic [2:0] OP_POW  = 3'd5;

    // Status codes.
    localparam logic [1:0] ST_OK       = 2'd0;
    localparam logic [1:0] ST_DIV_ZERO = 2'd1;
    localparam logic [1:0] ST_BAD_OP   = 2'd2;

    // Width of the multiplier digit consumed per cycle.
    localparam int MUL_DIGIT_W = 16;

    // Datapath actions issued by the controller.
    localparam logic [3:0] DP_NOP       = 4'd0;
    localparam logic [3:0] DP_ADD       = 4'd1;
    localparam logic [3:0] DP_SUB       = 4'd2;
    localparam logic [3:0] DP_SET_ONE   = 4'd3;
    localparam logic [3:0] DP_FACT_INIT = 4'd4;
    localparam logic [3:0] DP_POW_INIT  = 4'd5;
    localparam logic [3:0] DP_DIV_INIT  = 4'd6;
    localparam logic [3:0] DP_DIV_STEP  = 4'd7;
    localparam logic [3:0] DP_DIV_FIX   = 4'd8;
    localparam logic [3:0] DP_RES_PROD  = 4'd9;
    localparam logic [3:0] DP_FACT_PROD = 4'd10;
    localparam logic [3:0] DP_BASE_PROD = 4'd11;

    // Multiplier operand selections.
    localparam logic [1:0] MS_A_B        = 2'd0;
    localparam logic [1:0] MS_RES_CNT    = 2'd1;
    localparam logic [1:0] MS_RES_BASE   = 2'd2;
    localparam logic [1:0] MS_BASE_BASE  = 2'd3;

    // Command from controller to datapath.
    typedef struct packed {
        logic       load;
        logic [3:0] act;
        logic       mul_start;
        logic [1:0] mul_sel;
        logic       commit;
        logic [1:0] status;
    } dp_cmd_t;

    // Status from datapath to controller.
    typedef struct packed {
        logic [2:0] opcode;
        logic       a_neg;
        logic       a_zero;
        logic       b_neg;
        logic       b_zero;
        logic       e_zero;
        logic       e_lsb;
        logic       fact_done;
        logic       div_done;
        logic       mul_done;
    } dp_stat_t;

endpackage

// ===== hw/rtl/ica_mul.sv =====
// Iterative multiplier returning the product modulo 2^WIDTH.
// Consumes one digit of the multiplier per cycle and stops early once it runs out.
// Depends on ica_pkg.
`timescale 1ns / 1ps

module ica_mul #(
    parameter int WIDTH = 32
) (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             start,
    input  logic [WIDTH-1:0] a,
    input  logic [WIDTH-1:0] b,
    output logic             done,
    output logic [WIDTH-1:0] product
);
    import ica_pkg::*;

    localparam int DIG_W = (WIDTH < MUL_DIGIT_W) ? WIDTH : MUL_DIGIT_W;

    logic                     active_reg;
    logic                     active_next;
    logic [WIDTH-1:0]         acc_reg;
    logic [WIDTH-1:0]         acc_next;
    logic [WIDTH-1:0]         mcand_reg;
    logic [WIDTH-1:0]         mcand_next;
    logic [WIDTH-1:0]         mplier_reg;
    logic [WIDTH-1:0]         mplier_next;
    logic [WIDTH+DIG_W-1:0]   partial;

    // One partial product per cycle.
    assign partial = mcand_reg * mplier_reg[DIG_W-1:0];

    assign done    = active_reg && (mplier_reg == '0);
    assign product = acc_reg;

    // Load on start, then shift-and-accumulate until the multiplier is empty.
    always_comb
    begin
        active_next = active_reg;
        acc_next    = acc_reg;
        mcand_next  = mcand_reg;
        mplier_next = mplier_reg;
        if (start)
        begin
            active_next = 1'b1;
            acc_next    = '0;
            mcand_next  = a;
            mplier_next = b;
        end
        else if (active_reg)
        begin
            if (mplier_reg == '0)
            begin
                active_next = 1'b0;
            end
            else
            begin
                acc_next    = acc_reg + partial[WIDTH-1:0];
                mcand_next  = mcand_reg << DIG_W;
                mplier_next = mplier_reg >> DIG_W;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            active_reg <= 1'b0;
        end
        else
        begin
            active_reg <= active_next;
        end
    end

    always_ff @(posedge clk)
    begin
        acc_reg    <= acc_next;
        mcand_reg  <= mcand_next;
        mplier_reg <= mplier_next;
    end

endmodule

// ===== hw/rtl/ica_dp.sv =====
// Datapath of the integer calculator ALU: operand, result, divider and output registers.
// Executes controller commands and reports flags back; holds the shared multiplier.
// Depends on ica_pkg and ica_mul.
`timescale 1ns / 1ps

module ica_dp #(
    parameter int DATA_WIDTH = 32
) (
    input  logic               clk,
    input  logic               rst_n,
    input  ica_pkg::in_word_t  in_word,
    input  ica_pkg::dp_cmd_t   cmd,
    output ica_pkg::dp_stat_t  stat,
    output ica_pkg::out_word_t out_word
);
    import ica_pkg::*;

    localparam int W     = DATA_WIDTH;
    localparam int CNT_W = $clog2(DATA_WIDTH + 4);
    localparam logic [W-1:0]     FACT_MAX   = W'(DATA_WIDTH + 2);
    localparam logic [CNT_W-1:0] FACT_MAX_C = CNT_W'(DATA_WIDTH + 2);
    localparam logic [CNT_W-1:0] DIV_STEPS  = CNT_W'(DATA_WIDTH);
    localparam logic [W-1:0]     ONE        = W'(1);

    logic [2:0]       opc_reg, opc_next;
    logic [W-1:0]     opa_reg, opa_next;
    logic [W-1:0]     opb_reg, opb_next;
    logic [W-1:0]     res_reg, res_next;
    logic [W-1:0]     base_reg, base_next;
    logic [W-1:0]     rem_reg, rem_next;
    logic [CNT_W-1:0] cnt_reg, cnt_next;
    logic [CNT_W-1:0] lim_reg, lim_next;
    logic             neg_reg, neg_next;
    logic [W-1:0]     last_reg, last_next;
    out_word_t        out_reg, out_next;

    logic [W-1:0]     a_norm;
    logic [W-1:0]     b_norm;
    logic [W:0]       trial;
    logic [W-1:0]     mul_a;
    logic [W-1:0]     mul_b;
    logic             mul_done;
    logic [W-1:0]     mul_prod;
    logic [W-1:0]     commit_val;

    // Operands are sign-extended or wrapped to the internal width.
    assign a_norm = W'(in_word.operand_a);
    assign b_norm = W'(in_word.operand_b);

    // Restoring divider trial subtraction.
    assign trial = {rem_reg, opa_reg[W-1]} - {1'b0, base_reg};

    // Multiplier operand selection.
    always_comb
    begin
        case (cmd.mul_sel)
            MS_A_B:
            begin
                mul_a = opa_reg;
                mul_b = opb_reg;
            end
            MS_RES_CNT:
            begin
                mul_a = res_reg;
                mul_b = W'(cnt_reg);
            end
            MS_RES_BASE:
            begin
                mul_a = res_reg;
                mul_b = base_reg;
            end
            MS_BASE_BASE:
            begin
                mul_a = base_reg;
                mul_b = base_reg;
            end
            default:
            begin
                mul_a = opa_reg;
                mul_b = opb_reg;
            end
        endcase
    end

    ica_mul #(
        .WIDTH (W)
    ) u_mul (
        .clk     (clk),
        .rst_n   (rst_n),
        .start   (cmd.mul_start),
        .a       (mul_a),
        .b       (mul_b),
        .done    (mul_done),
        .product (mul_prod)
    );

    // Flags for the controller.
    always_comb
    begin
        stat.opcode    = opc_reg;
        stat.a_neg     = opa_reg[W-1];
        stat.a_zero    = (opa_reg == '0);
        stat.b_neg     = opb_reg[W-1];
        stat.b_zero    = (opb_reg == '0);
        stat.e_zero    = (opb_reg == '0);
        stat.e_lsb     = opb_reg[0];
        stat.fact_done = (cnt_reg > lim_reg);
        stat.div_done  = (cnt_reg == '0);
        stat.mul_done  = mul_done;
    end

    // Register updates per action.
    always_comb
    begin
        opc_next  = opc_reg;
        opa_next  = opa_reg;
        opb_next  = opb_reg;
        res_next  = res_reg;
        base_next = base_reg;
        rem_next  = rem_reg;
        cnt_next  = cnt_reg;
        lim_next  = lim_reg;
        neg_next  = neg_reg;

        if (cmd.load)
        begin
            opc_next = in_word.opcode;
            opa_next = a_norm;
            opb_next = b_norm;
        end

        case (cmd.act)
            DP_NOP:
            begin
                res_next = res_reg;
            end
            DP_ADD:
            begin
                res_next = opa_reg + opb_reg;
            end
            DP_SUB:
            begin
                res_next = opa_reg - opb_reg;
            end
            DP_SET_ONE:
            begin
                res_next = ONE;
            end
            DP_FACT_INIT:
            begin
                res_next = ONE;
                cnt_next = CNT_W'(1);
                lim_next = (opa_reg > FACT_MAX) ? FACT_MAX_C : opa_reg[CNT_W-1:0];
            end
            DP_POW_INIT:
            begin
                res_next  = ONE;
                base_next = opa_reg;
            end
            DP_DIV_INIT:
            begin
                // Work on magnitudes; the dividend register collects the quotient.
                opa_next  = opa_reg[W-1] ? ('0 - opa_reg) : opa_reg;
                base_next = opb_reg[W-1] ? ('0 - opb_reg) : opb_reg;
                rem_next  = '0;
                cnt_next  = DIV_STEPS;
                neg_next  = opa_reg[W-1] ^ opb_reg[W-1];
            end
            DP_DIV_STEP:
            begin
                if (!trial[W])
                begin
                    rem_next = trial[W-1:0];
                    opa_next = {opa_reg[W-2:0], 1'b1};
                end
                else
                begin
                    rem_next = {rem_reg[W-2:0], opa_reg[W-1]};
                    opa_next = {opa_reg[W-2:0], 1'b0};
                end
                cnt_next = cnt_reg - CNT_W'(1);
            end
            DP_DIV_FIX:
            begin
                res_next = neg_reg ? ('0 - opa_reg) : opa_reg;
            end
            DP_RES_PROD:
            begin
                res_next = mul_prod;
            end
            DP_FACT_PROD:
            begin
                res_next = mul_prod;
                cnt_next = cnt_reg + CNT_W'(1);
            end
            DP_BASE_PROD:
            begin
                base_next = mul_prod;
                opb_next  = opb_reg >> 1;
            end
            default:
            begin
                res_next = res_reg;
            end
        endcase
    end

    // Output word and last successful result.
    assign commit_val = (cmd.status == ST_OK) ? res_reg : last_reg;

    always_comb
    begin
        last_next = last_reg;
        out_next  = out_reg;
        if (cmd.commit)
        begin
            last_next       = commit_val;
            out_next.value  = 32'($signed(commit_val));
            out_next.status = cmd.status;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            last_reg <= '0;
        end
        else
        begin
            last_reg <= last_next;
        end
    end

    always_ff @(posedge clk)
    begin
        opc_reg  <= opc_next;
        opa_reg  <= opa_next;
        opb_reg  <= opb_next;
        res_reg  <= res_next;
        base_reg <= base_next;
        rem_reg  <= rem_next;
        cnt_reg  <= cnt_next;
        lim_reg  <= lim_next;
        neg_reg  <= neg_next;
        out_reg  <= out_next;
    end

    assign out_word = out_reg;

endmodule

// ===== hw/rtl/ica_ctrl.sv =====
// Controller of the integer calculator ALU: sequences one word at a time.
// Drives datapath commands from its flags and owns both channel handshakes.
// Depends on ica_pkg.
`timescale 1ns / 1ps

module ica_ctrl (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              in_valid,
    output logic              in_stall,
    output logic              out_valid,
    input  logic              out_stall,
    input  ica_pkg::dp_stat_t stat,
    output ica_pkg::dp_cmd_t  cmd
);
    import ica_pkg::*;

    localparam logic [3:0] S_IDLE      = 4'd0;
    localparam logic [3:0] S_DISPATCH  = 4'd1;
    localparam logic [3:0] S_MUL_WAIT  = 4'd2;
    localparam logic [3:0] S_DIV_RUN   = 4'd3;
    localparam logic [3:0] S_FACT_CHK  = 4'd4;
    localparam logic [3:0] S_FACT_WAIT = 4'd5;
    localparam logic [3:0] S_POW_CHK   = 4'd6;
    localparam logic [3:0] S_POW_RWAIT = 4'd7;
    localparam logic [3:0] S_POW_SWAIT = 4'd8;
    localparam logic [3:0] S_FINISH    = 4'd9;

    logic [3:0] state_reg, state_next;
    logic       out_valid_reg, out_valid_next;
    logic       out_free;
    logic [1:0] fin_status;

    assign in_stall  = (state_reg != S_IDLE);
    assign out_valid = out_valid_reg;
    assign out_free  = !out_valid_reg || !out_stall;

    // Result status is settled by the opcode and the divisor.
    always_comb
    begin
        if (stat.opcode == OP_ADD || stat.opcode == OP_SUB || stat.opcode == OP_MUL ||
            stat.opcode == OP_FACT || stat.opcode == OP_POW)
        begin
            fin_status = ST_OK;
        end
        else if (stat.opcode == OP_DIV)
        begin
            fin_status = stat.b_zero ? ST_DIV_ZERO : ST_OK;
        end
        else
        begin
            fin_status = ST_BAD_OP;
        end
    end

    // Next state and commands.
    always_comb
    begin
        state_next = state_reg;
        cmd        = '0;
        cmd.act    = DP_NOP;
        cmd.status = fin_status;

        case (state_reg)
            S_IDLE:
            begin
                if (in_valid)
                begin
                    cmd.load   = 1'b1;
                    state_next = S_DISPATCH;
                end
            end
            S_DISPATCH:
            begin
                case (stat.opcode)
                    OP_ADD:
                    begin
                        cmd.act    = DP_ADD;
                        state_next = S_FINISH;
                    end
                    OP_SUB:
                    begin
                        cmd.act    = DP_SUB;
                        state_next = S_FINISH;
                    end
                    OP_MUL:
                    begin
                        cmd.mul_start = 1'b1;
                        cmd.mul_sel   = MS_A_B;
                        state_next    = S_MUL_WAIT;
                    end
                    OP_DIV:
                    begin
                        if (stat.b_zero)
                        begin
                            state_next = S_FINISH;
                        end
                        else
                        begin
                            cmd.act    = DP_DIV_INIT;
                            state_next = S_DIV_RUN;
                        end
                    end
                    OP_FACT:
                    begin
                        if (stat.a_neg || stat.a_zero)
                        begin
                            cmd.act    = DP_SET_ONE;
                            state_next = S_FINISH;
                        end
                        else
                        begin
                            cmd.act    = DP_FACT_INIT;
                            state_next = S_FACT_CHK;
                        end
                    end
                    OP_POW:
                    begin
                        if (stat.b_neg)
                        begin
                            cmd.act    = DP_SET_ONE;
                            state_next = S_FINISH;
                        end
                        else
                        begin
                            cmd.act    = DP_POW_INIT;
                            state_next = S_POW_CHK;
                        end
                    end
                    default:
                    begin
                        state_next = S_FINISH;
                    end
                endcase
            end
            S_MUL_WAIT:
            begin
                if (stat.mul_done)
                begin
                    cmd.act    = DP_RES_PROD;
                    state_next = S_FINISH;
                end
            end
            S_DIV_RUN:
            begin
                if (stat.div_done)
                begin
                    cmd.act    = DP_DIV_FIX;
                    state_next = S_FINISH;
                end
                else
                begin
                    cmd.act = DP_DIV_STEP;
                end
            end
            S_FACT_CHK:
            begin
                if (stat.fact_done)
                begin
                    state_next = S_FINISH;
                end
                else
                begin
                    cmd.mul_start = 1'b1;
                    cmd.mul_sel   = MS_RES_CNT;
                    state_next    = S_FACT_WAIT;
                end
            end
            S_FACT_WAIT:
            begin
                if (stat.mul_done)
                begin
                    cmd.act    = DP_FACT_PROD;
                    state_next = S_FACT_CHK;
                end
            end
            S_POW_CHK:
            begin
                // Multiply into the result on a set exponent bit, then square the base.
                if (stat.e_zero)
                begin
                    state_next = S_FINISH;
                end
                else if (stat.e_lsb)
                begin
                    cmd.mul_start = 1'b1;
                    cmd.mul_sel   = MS_RES_BASE;
                    state_next    = S_POW_RWAIT;
                end
                else
                begin
                    cmd.mul_start = 1'b1;
                    cmd.mul_sel   = MS_BASE_BASE;
                    state_next    = S_POW_SWAIT;
                end
            end
            S_POW_RWAIT:
            begin
                if (stat.mul_done)
                begin
                    cmd.act       = DP_RES_PROD;
                    cmd.mul_start = 1'b1;
                    cmd.mul_sel   = MS_BASE_BASE;
                    state_next    = S_POW_SWAIT;
                end
            end
            S_POW_SWAIT:
            begin
                if (stat.mul_done)
                begin
                    cmd.act    = DP_BASE_PROD;
                    state_next = S_POW_CHK;
                end
            end
            S_FINISH:
            begin
                if (out_free)
                begin
                    cmd.commit = 1'b1;
                    state_next = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    // Output word valid flag.
    always_comb
    begin
        if (cmd.commit)
        begin
            out_valid_next = 1'b1;
        end
        else if (!out_stall)
        begin
            out_valid_next = 1'b0;
        end
        else
        begin
            out_valid_next = out_valid_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            out_valid_reg <= out_valid_next;
        end
    end

endmodule

// ===== hw/rtl/integer_calculator_alu.sv =====
// Top level of the integer calculator ALU.
// Joins the controller and the datapath; depends on ica_pkg, ica_ctrl, ica_dp.
`timescale 1ns / 1ps

// Integer calculator ALU. Each input word carries an opcode and two signed
// operands and yields one output word: add, subtract, multiply, truncating
// divide, factorial of operand_a, or operand_a to the power operand_b, all
// wrapped to DATA_WIDTH bits and sign-extended (or truncated) to 32 bits.
// A zero divisor or an unknown opcode reports a nonzero status and repeats
// the last good value. One word is processed at a time. Multiply, factorial
// and power share one multiplier that retires a 16-bit digit of the
// multiplier operand per cycle. Factorial multiplies at most DATA_WIDTH+2
// factors. Divide runs a restoring divider at one quotient bit per cycle.
// A new word is taken while the previous result still waits in the output
// register.
module integer_calculator_alu #(
    parameter int DATA_WIDTH = 32
) (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               op_valid,
    output logic               op_stall,
    input  ica_pkg::in_word_t  op_word,
    output logic               res_valid,
    input  logic               res_stall,
    output ica_pkg::out_word_t res_word
);
    import ica_pkg::*;

    dp_cmd_t  cmd;
    dp_stat_t stat;

    // Sequencer.
    ica_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (op_valid),
        .in_stall  (op_stall),
        .out_valid (res_valid),
        .out_stall (res_stall),
        .stat      (stat),
        .cmd       (cmd)
    );

    // Arithmetic and result registers.
    ica_dp #(
        .DATA_WIDTH (DATA_WIDTH)
    ) u_dp (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_word  (op_word),
        .cmd      (cmd),
        .stat     (stat),
        .out_word (res_word)
    );

endmodule

// ===== dv/tb_integer_calculator_alu.sv =====
// Self-checking testbench for the integer calculator ALU: directed corner words,
// a backpressure test and random words under several idle patterns.
// Depends on ica_pkg and integer_calculator_alu.
`timescale 1ns / 1ps

module tb_integer_calculator_alu;

    import ica_pkg::*;

    // Opcodes that the block must reject.
    localparam logic [2:0] OP_BAD_LO = 3'd6;
    localparam logic [2:0] OP_BAD_HI = 3'd7;

    localparam logic signed [31:0] S_MIN = 32'sh8000_0000;
    localparam logic signed [31:0] S_MAX = 32'sh7FFF_FFFF;

    // Factorial stops after this many factors at a 32-bit width.
    localparam int FACT_FACTORS = 34;

    localparam int CYCLE_LIMIT  = 2_000_000;
    localparam int DRAIN_CYCLES = 400;
    localparam int REPORT_LIMIT = 100;

    logic      clk = 1'b0;
    logic      rst_n = 1'b0;
    logic      op_valid = 1'b0;
    logic      op_stall;
    in_word_t  op_word = '0;
    logic      res_valid;
    logic      res_stall = 1'b0;
    out_word_t res_word;

    // Last value that completed with a good status.
    logic [31:0] last_good_value = '0;
    out_word_t   pending_results[$];
    out_word_t   oldest_result;

    int send_idle_pct  = 0;
    int recv_stall_pct = 0;
    int hold_request   = 0;
    int hold_left      = 0;
    int fail_count     = 0;
    int cycle_count    = 0;

    integer_calculator_alu i_dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .op_valid  (op_valid),
        .op_stall  (op_stall),
        .op_word   (op_word),
        .res_valid (res_valid),
        .res_stall (res_stall),
        .res_word  (res_word)
    );

    always
    begin
        #1 clk = 1'b1;
        #1 clk = 1'b0;
    end

    // Work out the result word of one input word and update the last good value.
    function automatic out_word_t compute_result(input in_word_t word);
        logic [31:0] a;
        logic [31:0] b;
        logic [31:0] r;
        logic [31:0] ma;
        logic [31:0] mb;
        logic [31:0] x;
        logic [1:0]  st;
        out_word_t   result;
        int          n;
        int          i;
        a  = word.operand_a;
        b  = word.operand_b;
        r  = '0;
        st = ST_OK;
        case (word.opcode)
            OP_ADD: r = a + b;
            OP_SUB: r = a - b;
            OP_MUL: r = a * b;
            OP_DIV:
            begin
                if (b == '0)
                begin
                    st = ST_DIV_ZERO;
                end
                else
                begin
                    // Divide the magnitudes, then restore the sign (truncation).
                    ma = a[31] ? (32'd0 - a) : a;
                    mb = b[31] ? (32'd0 - b) : b;
                    r  = ma / mb;
                    if (a[31] != b[31])
                    begin
                        r = 32'd0 - r;
                    end
                end
            end
            OP_FACT:
            begin
                r = 32'd1;
                if (!a[31] && a != '0)
                begin
                    n = (a > FACT_FACTORS) ? FACT_FACTORS : int'(a);
                    for (i = 1; i <= n; i++)
                    begin
                        r = r * 32'(i);
                    end
                end
            end
            OP_POW:
            begin
                // A negative exponent gives one; otherwise square and multiply.
                r = 32'd1;
                if (!b[31])
                begin
                    x = a;
                    for (i = 0; i < 32; i++)
                    begin
                        if (b[i])
                        begin
                            r = r * x;
                        end
                        x = x * x;
                    end
                end
            end
            default: st = ST_BAD_OP;
        endcase
        if (st == ST_OK)
        begin
            last_good_value = r;
        end
        result.value  = last_good_value;
        result.status = st;
        return result;
    endfunction

    // Offer one word after a random idle stretch and hold it until it is taken.
    task automatic send_op(input logic [2:0] op, input logic signed [31:0] a,
                           input logic signed [31:0] b);
        in_word_t word;
        word.opcode    = op;
        word.operand_a = a;
        word.operand_b = b;
        while ($urandom_range(99) < send_idle_pct)
        begin
            op_valid <= 1'b0;
            @(posedge clk);
        end
        op_valid <= 1'b1;
        op_word  <= word;
        do
            @(posedge clk);
        while (op_stall);
        pending_results.push_back(compute_result(word));
    endtask

    // Operands lean toward the extremes and small values.
    function automatic logic signed [31:0] pick_operand();
        case ($urandom_range(9))
            0: return S_MIN;
            1: return S_MAX;
            2: return 32'sd0;
            3: return -32'sd1;
            4: return 32'sd1;
            5, 6: return int'($urandom_range(200)) - 100;
            default: return $urandom;
        endcase
    endfunction

    task automatic send_random_word();
        logic [2:0]         op;
        logic signed [31:0] a;
        logic signed [31:0] b;
        if ($urandom_range(99) < 6)
        begin
            op = $urandom_range(1) ? OP_BAD_HI : OP_BAD_LO;
        end
        else
        begin
            op = 3'($urandom_range(5));
        end
        a = pick_operand();
        b = pick_operand();
        // Most factorials and powers use small arguments to keep them short.
        case (op)
            OP_DIV:  if ($urandom_range(15) == 0) b = '0;
            OP_FACT: if ($urandom_range(3) != 0) a = int'($urandom_range(44)) - 4;
            OP_POW:  if ($urandom_range(3) != 0) b = int'($urandom_range(40)) - 4;
            default: ;
        endcase
        send_op(op, a, b);
    endtask

    task automatic test_arith_edges();
        send_op(OP_ADD, S_MAX, 32'sd1);
        send_op(OP_ADD, S_MIN, S_MIN);
        send_op(OP_SUB, S_MIN, 32'sd1);
        send_op(OP_SUB, 32'sd0, S_MIN);
        send_op(OP_MUL, S_MIN, -32'sd1);
        send_op(OP_MUL, S_MAX, S_MAX);
    endtask

    task automatic test_divide_cases();
        send_op(OP_DIV, 32'sd1234, 32'sd0);
        send_op(OP_DIV, 32'sd0, 32'sd5);
        send_op(OP_DIV, S_MIN, -32'sd1);
        send_op(OP_DIV, -32'sd7, 32'sd2);
        send_op(OP_DIV, 32'sd7, -32'sd2);
    endtask

    task automatic test_factorial_cases();
        send_op(OP_FACT, 32'sd0, 32'sd3);
        send_op(OP_FACT, -32'sd5, 32'sd0);
        send_op(OP_FACT, 32'sd12, 32'sd0);
        send_op(OP_FACT, 32'sd13, 32'sd0);
        send_op(OP_FACT, 32'sd34, 32'sd0);
        send_op(OP_FACT, S_MAX, S_MIN);
    endtask

    task automatic test_power_cases();
        send_op(OP_POW, 32'sd0, 32'sd0);
        send_op(OP_POW, 32'sd7, S_MIN);
        send_op(OP_POW, 32'sd2, 32'sd31);
        send_op(OP_POW, -32'sd1, S_MAX);
        send_op(OP_POW, 32'sd3, S_MAX);
    endtask

    task automatic test_bad_opcodes();
        send_op(OP_BAD_LO, S_MAX, S_MIN);
        send_op(OP_BAD_HI, $urandom, $urandom);
    endtask

    // The receiver holds off for a long stretch while words keep coming.
    task automatic test_backpressure();
        int k;
        send_idle_pct  = 0;
        recv_stall_pct = 0;
        hold_request   = 200;
        for (k = 0; k < 8; k++)
        begin
            send_random_word();
        end
    endtask

    task automatic test_random_phase(input int idle_pct, input int stall_pct,
                                     input int count);
        int k;
        send_idle_pct  = idle_pct;
        recv_stall_pct = stall_pct;
        for (k = 0; k < count; k++)
        begin
            send_random_word();
        end
    endtask

    // Receiver stall: a requested hold-off first, random stalls otherwise.
    always @(posedge clk)
    begin
        if (hold_request > 0)
        begin
            hold_left    = hold_request;
            hold_request = 0;
        end
        if (hold_left > 0)
        begin
            hold_left = hold_left - 1;
            res_stall <= 1'b1;
        end
        else
        begin
            res_stall <= ($urandom_range(99) < recv_stall_pct);
        end
    end

    // Compare each accepted result word with the oldest expected one.
    always @(posedge clk)
    begin
        if (rst_n && res_valid && !res_stall)
        begin
            if (pending_results.size() == 0)
            begin
                fail_count++;
                if (fail_count <= REPORT_LIMIT)
                begin
                    $display("%0t: unexpected result word, expected none, actual value %h status %0d",
                             $time, res_word.value, res_word.status);
                end
            end
            else
            begin
                oldest_result = pending_results.pop_front();
                if (res_word.value !== oldest_result.value)
                begin
                    fail_count++;
                    if (fail_count <= REPORT_LIMIT)
                    begin
                        $display("%0t: value mismatch, expected %h actual %h",
                                 $time, oldest_result.value, res_word.value);
                    end
                end
                if (res_word.status !== oldest_result.status)
                begin
                    fail_count++;
                    if (fail_count <= REPORT_LIMIT)
                    begin
                        $display("%0t: status mismatch, expected %0d actual %0d",
                                 $time, oldest_result.status, res_word.status);
                    end
                end
            end
        end
    end

    // Watchdog on the whole run.
    always @(posedge clk)
    begin
        cycle_count++;
        if (cycle_count > CYCLE_LIMIT)
        begin
            $display("tb: failure");
            $finish;
        end
    end

    initial
    begin
        repeat (12) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        send_idle_pct  = 30;
        recv_stall_pct = 30;
        test_arith_edges();
        test_divide_cases();
        test_factorial_cases();
        test_power_cases();
        test_bad_opcodes();
        test_backpressure();

        test_random_phase(0, 0, 380);
        test_random_phase(80, 0, 350);
        test_random_phase(0, 80, 350);
        test_random_phase(16, 16, 350);

        // Stop offering words and let the last results drain.
        op_valid <= 1'b0;
        while (pending_results.size() != 0)
        begin
            @(posedge clk);
        end
        repeat (DRAIN_CYCLES) @(posedge clk);

        if (fail_count == 0)
        begin
            $display("tb: success");
        end
        else
        begin
            $display("tb: failure");
        end
        $finish;
    end

endmodule

// ===== files.f =====
hw/rtl/ica_pkg.sv
hw/rtl/ica_mul.sv
hw/rtl/ica_dp.sv
hw/rtl/ica_ctrl.sv
hw/rtl/integer_calculator_alu.sv
dv/tb_integer_calculator_alu.sv
